### rtl/core/dhfk_pkg.sv
// Shared types and constants for the DH forward kinematics chain.
package dhfk_pkg;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_JOINT = 1'b1;

  localparam logic REG_JOINT_COUNT = 1'b0;
  localparam logic REG_TOOL_ENABLE = 1'b1;

  localparam int CFG_DATA_W = 4;

  localparam logic signed [31:0] ONE_Q16     = 32'sd65536;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic              func;
    logic [3:0]        entry_index;
    logic              joint_kind;
    logic signed [31:0] twist_angle;
    logic signed [31:0] link_length;
    logic signed [31:0] link_offset;
    logic signed [31:0] angle_offset;
    logic signed [31:0] joint_value;
  } in_t;

  typedef struct packed {
    logic [3:0]         frame_index;
    logic [1:0]         row_index;
    logic signed [31:0] col_x;
    logic signed [31:0] col_y;
    logic signed [31:0] col_z;
    logic signed [31:0] col_pos;
    logic               last_row;
  } out_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/dhfk_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dhfk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### rtl/core/dhfk_cordic.sv
// Iterative rotation-mode CORDIC giving Q16 sine and cosine of a binary angle.
module dhfk_cordic #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               busy,
  output logic signed [31:0] sin_q,
  output logic signed [31:0] cos_q
);
  import dhfk_pkg::*;

  localparam int N    = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int CNTW = $clog2(N);

  logic signed [33:0] x, y, z;
  logic               fold;
  logic [CNTW-1:0]    cnt;
  logic [4:0]         idx;
  logic signed [33:0] dx, dy, at;
  logic               fold_c;
  logic [31:0]        a_c;
  logic signed [33:0] xr, yr;

  assign idx    = 5'(cnt);
  assign dx     = y >>> idx;
  assign dy     = x >>> idx;
  assign at     = $signed({2'b00, atan_lut(idx)});
  assign fold_c = (angle + 32'h40000000) >> 31 != 32'd0;
  assign a_c    = fold_c ? angle + 32'h80000000 : angle;
  assign xr     = (x + 34'sd8192) >>> 14;
  assign yr     = (y + 34'sd8192) >>> 14;
  assign cos_q  = fold ? -xr[31:0] : xr[31:0];
  assign sin_q  = fold ? -yr[31:0] : yr[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      fold <= fold_c;
      x    <= CORDIC_GAIN;
      y    <= '0;
      z    <= {{2{a_c[31]}}, a_c};
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - at;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + at;
      end
      cnt <= cnt + 1'b1;
      if (cnt == CNTW'(N - 1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

### rtl/core/dh_forward_kinematics_chain.sv
// Top level: DH serial-chain forward kinematics with table and transform memories.
//
//  port group   | dir | handshake            | payload
//  in_*         | in  | in_valid / in_stall  | dhfk_pkg::in_t (load or joint value)
//  out_*        | out | out_valid / out_stall| dhfk_pkg::out_t (one transform row)
//  cfg_*        | in  | cfg_we               | joint_count, tool_enable
//
// A load item is written to the entry table while the sequencer stays idle. A joint
// item runs two CORDIC passes (joint angle, then twist), 6 products to build the link
// matrix, then per row 4 transform reads, 12 products on the shared multiplier and 4
// writes; a second frame follows when the tool frame is enabled after the last joint.
// Reset (rst, synchronous) restores identity transform and position 0.
// A stalled output holds the sequencer in its identity or emit step; input stalls while busy.
module dh_forward_kinematics_chain #(
  parameter int MAX_JOINTS   = 8,
  parameter int CORDIC_STEPS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  dhfk_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output dhfk_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [dhfk_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dhfk_pkg::*;

  localparam int TAW = $clog2(MAX_JOINTS + 1);
  localparam int PW  = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int TW  = 129;

  localparam logic signed [49:0] SAT_HI = 50'sd2147483647;
  localparam logic signed [49:0] SAT_LO = -50'sd2147483648;

  typedef enum logic [3:0] {
    S_IDLE, S_RDTAB, S_LATCH, S_IDEM, S_COR1, S_COR2, S_BUILD, S_BFIN,
    S_ROWRD, S_ROWMUL, S_ROWFIN, S_ROWWR, S_EMIT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > SAT_HI) return 32'sh7fffffff;
    else if (v < SAT_LO) return 32'sh80000000;
    else return v[31:0];
  endfunction

  state_t             state;
  logic [3:0]         joint_count;
  logic               tool_enable;
  logic [PW-1:0]      pos;
  logic               tool;
  logic signed [31:0] q;
  logic signed [31:0] alpha, a_len, d;
  logic signed [31:0] st, ct, sa, ca;
  logic signed [31:0] m [3][4];
  logic signed [31:0] rrow [4];
  logic signed [31:0] nrow [4];
  logic signed [49:0] acc;
  logic [1:0]         r, k, col;
  logic [2:0]         cnt;
  logic [11:0]        vld;
  logic signed [63:0] prod;
  logic               prod_vld;
  logic               prod_bld;
  logic [3:0]         prod_tag;

  logic               in_acc, ofree;
  logic [TAW-1:0]     count;
  logic               last_joint;
  logic               tab_we, tab_re;
  logic [TAW-1:0]     tab_waddr, tab_raddr;
  logic [TW-1:0]      tab_wdata, tab_rdata;
  logic               rt_we, rt_re;
  logic [3:0]         rt_waddr, rt_raddr, rt_caddr;
  logic [31:0]        rt_rdata;
  logic signed [31:0] rt_val;
  logic               t_prism;
  logic signed [31:0] t_twist, t_len, t_off, t_ang;
  logic [31:0]        theta_c;
  logic signed [32:0] dsum;
  logic signed [31:0] d_c;
  logic               cord_start, cord_busy;
  logic [31:0]        cord_ang;
  logic signed [31:0] cord_sin, cord_cos;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] rnd;
  logic signed [49:0] mq, base, sum;
  logic [3:0]         fidx;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign ofree    = !out_valid || !out_stall;

  always_comb begin
    if (joint_count == 4'd0) count = TAW'(1);
    else if (int'(joint_count) > MAX_JOINTS) count = TAW'(MAX_JOINTS);
    else count = TAW'(joint_count);
  end
  assign last_joint = (TAW'(pos) + TAW'(1)) >= count;

  // entry table: {prismatic, twist, length, offset, angle}
  assign tab_we    = in_acc && (in_data.func == FUNC_LOAD)
                     && (int'(in_data.entry_index) <= MAX_JOINTS);
  assign tab_waddr = TAW'(in_data.entry_index);
  assign tab_wdata = {in_data.joint_kind, in_data.twist_angle, in_data.link_length,
                      in_data.link_offset, in_data.angle_offset};
  assign {t_prism, t_twist, t_len, t_off, t_ang} = tab_rdata;

  always_comb begin
    tab_re    = 1'b0;
    tab_raddr = TAW'(pos);
    if (state == S_IDLE && in_acc && in_data.func == FUNC_JOINT) begin
      tab_re = 1'b1;
    end else if (state == S_EMIT && ofree && r == 2'd2 && !tool && last_joint
                 && tool_enable) begin
      tab_re    = 1'b1;
      tab_raddr = TAW'(MAX_JOINTS);
    end
  end

  dhfk_ram #(.WIDTH(TW), .DEPTH(MAX_JOINTS + 1)) u_tab (
    .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
    .re(tab_re), .raddr(tab_raddr), .rdata(tab_rdata)
  );

  // running transform, entry = row*4 + column
  assign rt_re    = (state == S_ROWRD) && (cnt < 3'd4);
  assign rt_raddr = {r, cnt[1:0]};
  assign rt_caddr = {r, 2'(cnt - 3'd1)};
  assign rt_we    = (state == S_ROWWR);
  assign rt_waddr = {r, cnt[1:0]};
  assign rt_val   = vld[rt_caddr] ? $signed(rt_rdata) :
                    ((rt_caddr == 4'd0 || rt_caddr == 4'd5 || rt_caddr == 4'd10)
                     ? ONE_Q16 : 32'sd0);

  dhfk_ram #(.WIDTH(32), .DEPTH(12)) u_rt (
    .clk(clk), .we(rt_we), .waddr(rt_waddr), .wdata(nrow[cnt[1:0]]),
    .re(rt_re), .raddr(rt_raddr), .rdata(rt_rdata)
  );

  assign theta_c = t_ang + ((!tool && !t_prism) ? q : 32'sd0);
  assign dsum    = 33'(t_off) + 33'(q);
  assign d_c     = (!tool && t_prism) ? sat32(50'(dsum)) : t_off;

  assign cord_start = (state == S_LATCH) || (state == S_COR1 && !cord_busy);
  assign cord_ang   = (state == S_LATCH) ? theta_c : alpha;

  dhfk_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cord_start), .angle(cord_ang),
    .busy(cord_busy), .sin_q(cord_sin), .cos_q(cord_cos)
  );

  always_comb begin
    mul_a = rrow[k];
    mul_b = m[k][col];
    if (state == S_BUILD) begin
      case (cnt)
        3'd0:    begin mul_a = st; mul_b = ca;      end
        3'd1:    begin mul_a = ct; mul_b = ca;      end
        3'd2:    begin mul_a = st; mul_b = sa;      end
        3'd3:    begin mul_a = ct; mul_b = sa;      end
        3'd4:    begin mul_a = d;  mul_b = m[1][2]; end
        default: begin mul_a = d;  mul_b = ca;      end
      endcase
    end
  end

  assign rnd  = prod + 64'sd32768;
  assign mq   = 50'($signed(rnd[63:16]));
  assign base = (prod_tag[1:0] == 2'd0)
                ? ((prod_tag[3:2] == 2'd3) ? 50'(rrow[3]) : 50'sd0) : acc;
  assign sum  = base + mq;
  assign fidx = 4'(pos) + (tool ? 4'd2 : 4'd1);

  always_ff @(posedge clk) begin
    prod     <= mul_a * mul_b;
    prod_vld <= (state == S_BUILD) || (state == S_ROWMUL);
    prod_bld <= (state == S_BUILD);
    prod_tag <= (state == S_BUILD) ? {1'b0, cnt} : {col, k};

    if (prod_vld) begin
      if (prod_bld) begin
        case (prod_tag[2:0])
          3'd0:    m[1][0] <= sat32(mq);
          3'd1:    m[1][1] <= sat32(mq);
          3'd2:    m[2][0] <= sat32(mq);
          3'd3:    m[2][1] <= sat32(mq);
          3'd4:    m[1][3] <= sat32(mq);
          default: m[2][3] <= sat32(mq);
        endcase
      end else begin
        acc <= sum;
        if (prod_tag[1:0] == 2'd2) begin
          nrow[prod_tag[3:2]] <= sat32(sum);
        end
      end
    end

    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      joint_count <= 4'd6;
      tool_enable <= 1'b0;
      pos         <= '0;
      vld         <= '0;
      tool        <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !(state == S_IDEM || state == S_EMIT)) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_JOINT_COUNT: joint_count <= cfg_data[3:0];
          REG_TOOL_ENABLE: tool_enable <= cfg_data[0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_acc && in_data.func == FUNC_JOINT) begin
            q     <= in_data.joint_value;
            tool  <= 1'b0;
            state <= S_RDTAB;
          end
        end
        S_RDTAB: state <= S_LATCH;
        S_LATCH: begin
          alpha <= t_twist;
          a_len <= t_len;
          d     <= d_c;
          r     <= 2'd0;
          state <= (pos == '0 && !tool) ? S_IDEM : S_COR1;
        end
        S_IDEM: begin
          if (ofree) begin
            out_valid            <= 1'b1;
            out_data.frame_index <= 4'd0;
            out_data.row_index   <= r;
            out_data.col_x       <= (r == 2'd0) ? ONE_Q16 : 32'sd0;
            out_data.col_y       <= (r == 2'd1) ? ONE_Q16 : 32'sd0;
            out_data.col_z       <= (r == 2'd2) ? ONE_Q16 : 32'sd0;
            out_data.col_pos     <= 32'sd0;
            out_data.last_row    <= 1'b0;
            if (r == 2'd2) begin
              r     <= 2'd0;
              state <= S_COR1;
            end else begin
              r <= r + 2'd1;
            end
          end
        end
        S_COR1: begin
          if (!cord_busy) begin
            st    <= cord_sin;
            ct    <= cord_cos;
            state <= S_COR2;
          end
        end
        S_COR2: begin
          if (!cord_busy) begin
            sa      <= cord_sin;
            ca      <= cord_cos;
            m[0][0] <= ct;
            m[0][1] <= -st;
            m[0][2] <= 32'sd0;
            m[0][3] <= a_len;
            m[1][2] <= -cord_sin;
            m[2][2] <= cord_cos;
            cnt     <= 3'd0;
            state   <= S_BUILD;
          end
        end
        S_BUILD: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd5) begin
            state <= S_BFIN;
          end
        end
        S_BFIN: begin
          r     <= 2'd0;
          cnt   <= 3'd0;
          state <= S_ROWRD;
        end
        S_ROWRD: begin
          if (cnt != 3'd0) begin
            rrow[2'(cnt - 3'd1)] <= rt_val;
          end
          cnt <= cnt + 3'd1;
          if (cnt == 3'd4) begin
            k     <= 2'd0;
            col   <= 2'd0;
            state <= S_ROWMUL;
          end
        end
        S_ROWMUL: begin
          if (k == 2'd2) begin
            k   <= 2'd0;
            col <= col + 2'd1;
            if (col == 2'd3) begin
              state <= S_ROWFIN;
            end
          end else begin
            k <= k + 2'd1;
          end
        end
        S_ROWFIN: begin
          cnt   <= 3'd0;
          state <= S_ROWWR;
        end
        S_ROWWR: begin
          vld[rt_waddr] <= 1'b1;
          cnt <= cnt + 3'd1;
          if (cnt == 3'd3) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (ofree) begin
            out_valid            <= 1'b1;
            out_data.frame_index <= fidx;
            out_data.row_index   <= r;
            out_data.col_x       <= nrow[0];
            out_data.col_y       <= nrow[1];
            out_data.col_z       <= nrow[2];
            out_data.col_pos     <= nrow[3];
            out_data.last_row    <= (r == 2'd2)
                                    && (tool || !last_joint || !tool_enable);
            if (r != 2'd2) begin
              r     <= r + 2'd1;
              cnt   <= 3'd0;
              state <= S_ROWRD;
            end else if (!tool && last_joint && tool_enable) begin
              tool  <= 1'b1;
              state <= S_RDTAB;
            end else if (tool || last_joint) begin
              vld   <= '0;
              pos   <= '0;
              state <= S_IDLE;
            end else begin
              pos   <= pos + 1'b1;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### test/tb_top.sv
// Testbench for the DH forward kinematics chain: predicts transform rows and checks them.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dhfk_pkg::*;

  localparam int NJ = 8;
  localparam int STEPS = 24;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_JOINT_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #2 clk = ~clk;

  dh_forward_kinematics_chain #(.MAX_JOINTS(NJ), .CORDIC_STEPS(STEPS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  int unsigned jcount;
  bit tool_on;
  logic signed [31:0] tw [NJ+1];
  logic signed [31:0] ln [NJ+1];
  logic signed [31:0] of [NJ+1];
  logic signed [31:0] an [NJ+1];
  bit pris [NJ];
  longint xf [3][4];
  int unsigned jpos;

  out_t rows_due[$];
  int errors = 0;
  int mism = 0;
  longint cycles = 0;
  bit quiet = 1'b0;

  function automatic longint asr64(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  function automatic longint atan_val(int i);
    logic [31:0] t [32] = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146,
      32'h000000A3, 32'h00000051, 32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
    return longint'(t[i]);
  endfunction

  task automatic sin_cos(input logic [31:0] ang, output longint s, output longint c);
    bit fold;
    logic [31:0] a;
    longint z, x, y, dx, dy;
    fold = ((ang + 32'h40000000) & 32'h80000000) != 0;
    a = fold ? ang + 32'h80000000 : ang;
    z = longint'(signed'(a));
    x = 652032874;
    y = 0;
    for (int i = 0; i < STEPS && i < 32; i++) begin
      dx = asr64(y, i);
      dy = asr64(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_val(i);
      end else begin
        x += dx; y -= dy; z += atan_val(i);
      end
    end
    x = (x + 8192) >>> 14;
    y = (y + 8192) >>> 14;
    c = fold ? -x : x;
    s = fold ? -y : y;
  endtask

  function automatic void reset_xf();
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 4; k++) xf[r][k] = (r == k) ? 65536 : 0;
  endfunction

  task automatic chain_link(input longint alpha, input longint a, input longint d,
                            input logic [31:0] theta);
    longint st, ct, sa, ca, acc;
    longint m [3][4];
    longint nt [3][4];
    sin_cos(theta, st, ct);
    sin_cos(alpha[31:0], sa, ca);
    m[0][0] = ct; m[0][1] = -st; m[0][2] = 0; m[0][3] = a;
    m[1][0] = qmul(st, ca); m[1][1] = qmul(ct, ca); m[1][2] = -sa;
    m[1][3] = sat(qmul(d, -sa));
    m[2][0] = qmul(st, sa); m[2][1] = qmul(ct, sa); m[2][2] = ca;
    m[2][3] = sat(qmul(d, ca));
    for (int r = 0; r < 3; r++)
      for (int cc = 0; cc < 4; cc++) begin
        acc = (cc == 3) ? xf[r][3] : 0;
        for (int k = 0; k < 3; k++) acc += qmul(xf[r][k], m[k][cc]);
        nt[r][cc] = sat(acc);
      end
    xf = nt;
  endtask

  function automatic void queue_frame(int unsigned fr, bit ident);
    out_t o;
    for (int r = 0; r < 3; r++) begin
      o.frame_index = fr[3:0];
      o.row_index = r[1:0];
      o.col_x = ident ? ((r == 0) ? 65536 : 0) : xf[r][0][31:0];
      o.col_y = ident ? ((r == 1) ? 65536 : 0) : xf[r][1][31:0];
      o.col_z = ident ? ((r == 2) ? 65536 : 0) : xf[r][2][31:0];
      o.col_pos = ident ? 0 : xf[r][3][31:0];
      o.last_row = 1'b0;
      rows_due.insert(rows_due.size(), o);
    end
  endfunction

  task automatic predict_item(input in_t it);
    int unsigned cnt, p;
    longint d;
    logic [31:0] th;
    if (it.func == FUNC_LOAD) begin
      if (it.entry_index <= NJ) begin
        tw[it.entry_index] = it.twist_angle;
        ln[it.entry_index] = it.link_length;
        of[it.entry_index] = it.link_offset;
        an[it.entry_index] = it.angle_offset;
        if (it.entry_index < NJ) pris[it.entry_index] = it.joint_kind;
      end
      return;
    end
    cnt = (jcount == 0) ? 1 : ((jcount > NJ) ? NJ : jcount);
    p = (jpos >= NJ) ? NJ - 1 : jpos;
    if (p == 0) queue_frame(0, 1'b1);
    th = an[p];
    d = of[p];
    if (pris[p]) d = sat(d + longint'(it.joint_value));
    else th += it.joint_value;
    chain_link(tw[p], ln[p], d, th);
    queue_frame(p + 1, 1'b0);
    if (p + 1 >= cnt) begin
      if (tool_on) begin
        chain_link(tw[NJ], ln[NJ], of[NJ], an[NJ]);
        queue_frame(p + 2, 1'b0);
      end
      reset_xf();
      jpos = 0;
    end else begin
      jpos = p + 1;
    end
    rows_due[$].last_row = 1'b1;
  endtask

  function automatic bit idle_now();
    return !quiet && ($urandom_range(99) < 13);
  endfunction

  task automatic send_item(input in_t it);
    predict_item(it);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (rows_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_JOINT_COUNT) jcount = 32'(val);
    else tool_on = val[0];
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(5))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return 32'($signed($urandom_range(0, 262143)) - 131072);
      default: return $urandom;
    endcase
  endfunction

  task automatic load_entry(input int e, input bit kind, input logic [31:0] al,
      input logic [31:0] a, input logic [31:0] d, input logic [31:0] th);
    in_t it;
    it.func = FUNC_LOAD; it.entry_index = e[3:0]; it.joint_kind = kind;
    it.twist_angle = al; it.link_length = a; it.link_offset = d;
    it.angle_offset = th; it.joint_value = $urandom;
    send_item(it);
  endtask

  task automatic joint_item(input logic [31:0] q);
    in_t it;
    it.func = FUNC_JOINT; it.entry_index = 4'($urandom); it.joint_kind = 1'($urandom);
    it.twist_angle = $urandom; it.link_length = $urandom; it.link_offset = $urandom;
    it.angle_offset = $urandom; it.joint_value = q;
    send_item(it);
  endtask

  task automatic load_random_table();
    for (int e = 0; e <= NJ; e++)
      load_entry(e, 1'($urandom), rnd_word(), rnd_word(), rnd_word(), rnd_word());
  endtask

  task automatic test_directed();
    load_entry(0, 1'b0, 32'h0, 32'h00010000, 32'h0, 32'h0);
    load_entry(1, 1'b1, 32'h40000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
    load_entry(2, 1'b0, 32'h80000000, 32'h80000000, 32'h80000000, 32'hC0000000);
    load_entry(3, 1'b1, 32'hC0000000, 32'h0, 32'h80000000, 32'h40000000);
    for (int e = 4; e < NJ; e++)
      load_entry(e, e[0], 32'hFFFFFFFF, 32'h00020000, 32'h00030000, 32'h7FFFFFFF);
    load_entry(NJ, 1'b1, 32'h20000000, 32'h00050000, 32'hFFFB0000, 32'h10000000);
    load_entry(9, 1'b1, 32'h1, 32'h1, 32'h1, 32'h1);
    load_entry(15, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0);
    joint_item(32'h40000000);
    joint_item(32'h7FFFFFFF);
    joint_item(32'h80000000);
    joint_item(32'h80000000);
    joint_item(32'h0);
    joint_item(32'hFFFFFFFF);
  endtask

  task automatic test_config_sweep();
    int unsigned counts [5] = '{1, 8, 0, 15, 3};
    for (int i = 0; i < 5; i++) begin
      write_reg(REG_JOINT_COUNT, CFG_DATA_W'(counts[i]));
      write_reg(REG_TOOL_ENABLE, CFG_DATA_W'(i[0]));
      for (int j = 0; j < 9; j++) joint_item(rnd_word());
    end
  endtask

  task automatic test_random_chains();
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_JOINT_COUNT, CFG_DATA_W'($urandom_range(1, 8)));
      write_reg(REG_TOOL_ENABLE, CFG_DATA_W'($urandom_range(1)));
      quiet = (ph == 2);
      load_random_table();
      for (int k = 0; k < 45; k++) begin
        if ($urandom_range(9) == 0)
          load_entry($urandom_range(15), 1'($urandom), rnd_word(), rnd_word(), rnd_word(),
                     rnd_word());
        else joint_item(rnd_word());
      end
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < 13) && !quiet;
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (rows_due.size() == 0) begin
        errors++;
        if (mism < 10) $display("unexpected row %p", out_data);
        mism++;
      end else begin
        want = rows_due.pop_front();
        if (out_data !== want) begin
          errors++;
          if (mism < 10) $display("row mismatch exp %p got %p", want, out_data);
          mism++;
        end
      end
    end
  end

  initial begin
    jcount = 6;
    tool_on = 1'b0;
    jpos = 0;
    reset_xf();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_random_chains();
    in_valid <= 1'b0;
    while (rows_due.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0 && rows_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

### sim.f
rtl/core/dhfk_pkg.sv
rtl/core/dhfk_ram.sv
rtl/core/dhfk_cordic.sv
rtl/core/dh_forward_kinematics_chain.sv
test/tb_top.sv
